[sv/sacrr_pkg.sv]
// shared constants, types and helper functions of the random-replacement cache tag store
package sacrr_pkg;

  // cache geometry: WAYS, SETS and BLOCK_BYTES are powers of two
  localparam int WAYS        = 64;
  localparam int SETS        = 1024;
  localparam int BLOCK_BYTES = 64;

  // field widths
  localparam int ADDR_W    = 48;
  localparam int GAP_W     = 16;
  localparam int TAG_W     = 32;
  localparam int CNT_W     = 48;
  localparam int SEED_W    = 16;
  localparam int OUT_WAY_W = 6;

  // derived widths
  localparam int OFFSET_W = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 0;
  localparam int SET_W    = $clog2(SETS);
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;

  // register port
  localparam int APB_AW = 2;
  localparam int APB_DW = 32;
  localparam logic [APB_AW-1:0] REG_SEED_ADDR = '0;

  // lfsr
  localparam logic [SEED_W-1:0] SEED_RESET  = 16'h0001;
  localparam logic [SEED_W-1:0] LFSR_TOGGLE = 16'hB400;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } ctrl_state_t;

  // seed reload request from the register block
  typedef struct packed {
    logic              load;
    logic [SEED_W-1:0] value;
  } seed_load_t;

  // a zero seed would lock the lfsr, so it starts from one instead
  function automatic logic [SEED_W-1:0] seed_to_lfsr(input logic [SEED_W-1:0] s);
    return (s == '0) ? SEED_RESET : s;
  endfunction

  // one galois step, shifting right
  function automatic logic [SEED_W-1:0] lfsr_step(input logic [SEED_W-1:0] v);
    logic [SEED_W-1:0] nv;
    nv = v >> 1;
    if (v[0]) begin
      nv = nv ^ LFSR_TOGGLE;
    end
    return nv;
  endfunction

  // set index from the byte address
  function automatic logic [SET_W-1:0] addr_set(input logic [ADDR_W-1:0] addr);
    logic [ADDR_W-1:0] sh;
    sh = addr >> OFFSET_W;
    return sh[SET_W-1:0];
  endfunction

  // low tag bits from the byte address
  function automatic logic [TAG_W-1:0] addr_tag(input logic [ADDR_W-1:0] addr);
    logic [ADDR_W-1:0] sh;
    sh = addr >> (OFFSET_W + SET_W);
    return sh[TAG_W-1:0];
  endfunction

endpackage

[sv/sacrr_if.sv]
// item channels: access requests in, lookup results out
interface sacrr_req_if
  import sacrr_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] byte_address;
  logic [GAP_W-1:0]  instr_gap;

  modport source (output valid, output byte_address, output instr_gap, input ready);
  modport sink   (input valid, input byte_address, input instr_gap, output ready);
endinterface

interface sacrr_rsp_if
  import sacrr_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [OUT_WAY_W-1:0] way;
  logic [CNT_W-1:0]     hit_total;
  logic [CNT_W-1:0]     access_total;
  logic [CNT_W-1:0]     instr_total;

  modport source (output valid, output hit, output way, output hit_total,
                  output access_total, output instr_total, input ready);
  modport sink   (input valid, input hit, input way, input hit_total,
                  input access_total, input instr_total, output ready);
endinterface

[sv/sacrr_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
module sacrr_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 1024,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data holds while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/sacrr_cfg.sv]
// register block: seed register behind the apb-style port
module sacrr_cfg
  import sacrr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output seed_load_t        seed_ld
);

  logic [SEED_W-1:0] seed;
  logic              seed_wr;

  // write strobe in the access phase
  assign seed_wr = psel && penable && pwrite && (paddr == REG_SEED_ADDR);
  assign pready  = 1'b1;

  // seed register
  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SEED_RESET;
    end else if (seed_wr) begin
      seed <= pwdata[SEED_W-1:0];
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (paddr == REG_SEED_ADDR) begin
      prdata = APB_DW'(seed);
    end
  end

  // a seed write reloads the lfsr at once
  assign seed_ld.load  = seed_wr;
  assign seed_ld.value = seed_to_lfsr(pwdata[SEED_W-1:0]);

endmodule

[sv/sacrr_ctrl.sv]
// lookup controller: valid clear sweep, tag compare, victim fill, totals and result register
module sacrr_ctrl
  import sacrr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  sacrr_req_if.sink              req,
  sacrr_rsp_if.source            rsp,
  input  seed_load_t             seed_ld,
  // tag ram
  output logic                   tag_we,
  output logic [SET_W-1:0]       tag_waddr,
  output logic [WAYS*TAG_W-1:0]  tag_wdata,
  output logic                   tag_re,
  output logic [SET_W-1:0]       tag_raddr,
  input  logic [WAYS*TAG_W-1:0]  tag_rdata,
  // valid ram
  output logic                   vld_we,
  output logic [SET_W-1:0]       vld_waddr,
  output logic [WAYS-1:0]        vld_wdata,
  output logic                   vld_re,
  output logic [SET_W-1:0]       vld_raddr,
  input  logic [WAYS-1:0]        vld_rdata
);

  ctrl_state_t state, state_next;

  logic [SET_W-1:0]  clr_addr;
  logic [SET_W-1:0]  cur_set;
  logic [TAG_W-1:0]  cur_tag;
  logic [GAP_W-1:0]  cur_gap;
  logic [SEED_W-1:0] lfsr;
  logic [CNT_W-1:0]  hit_cnt;
  logic [CNT_W-1:0]  acc_cnt;
  logic [CNT_W-1:0]  ins_cnt;

  logic              accept;
  logic              finish;
  logic [WAYS-1:0]   match;
  logic              hit;
  logic [WAY_W-1:0]  hit_way;
  logic [SEED_W-1:0] lfsr_adv;
  logic [WAY_W-1:0]  victim;

  // handshake
  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign finish    = (state == ST_LOOKUP) && (!rsp.valid || rsp.ready);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == SET_W'(SETS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (finish) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // clear sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clr_addr <= clr_addr + SET_W'(1);
    end
  end

  // capture the accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_set <= addr_set(req.byte_address);
      cur_tag <= addr_tag(req.byte_address);
      cur_gap <= req.instr_gap;
    end
  end

  // set read on accept
  assign tag_re    = accept;
  assign tag_raddr = addr_set(req.byte_address);
  assign vld_re    = accept;
  assign vld_raddr = addr_set(req.byte_address);

  // compare every way of the set, lowest match wins
  always_comb begin
    hit_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      match[w] = vld_rdata[w] && (tag_rdata[w*TAG_W +: TAG_W] == cur_tag);
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = WAY_W'(w);
      end
    end
  end
  assign hit = |match;

  // victim from the advanced lfsr
  assign lfsr_adv = lfsr_step(lfsr);
  assign victim   = (WAYS > 1) ? lfsr_adv[WAY_W-1:0] : '0;

  // fill on miss, valid clear during the sweep
  always_comb begin
    tag_wdata = tag_rdata;
    tag_wdata[victim*TAG_W +: TAG_W] = cur_tag;
    vld_wdata = vld_rdata;
    vld_wdata[victim] = 1'b1;
    tag_we    = finish && !hit;
    tag_waddr = cur_set;
    vld_we    = finish && !hit;
    vld_waddr = cur_set;
    if (state == ST_CLEAR) begin
      vld_we    = 1'b1;
      vld_waddr = clr_addr;
      vld_wdata = '0;
    end
  end

  // victim lfsr
  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr <= SEED_RESET;
    end else if (seed_ld.load) begin
      lfsr <= seed_ld.value;
    end else if (finish && !hit) begin
      lfsr <= lfsr_adv;
    end
  end

  // running totals
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_cnt <= '0;
      acc_cnt <= '0;
      ins_cnt <= '0;
    end else if (finish) begin
      if (hit) begin
        hit_cnt <= hit_cnt + CNT_W'(1);
      end
      acc_cnt <= acc_cnt + CNT_W'(1);
      ins_cnt <= ins_cnt + CNT_W'(cur_gap) + CNT_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (finish) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      rsp.hit          <= hit;
      rsp.way          <= OUT_WAY_W'(hit ? hit_way : victim);
      rsp.hit_total    <= hit ? hit_cnt + CNT_W'(1) : hit_cnt;
      rsp.access_total <= acc_cnt + CNT_W'(1);
      rsp.instr_total  <= ins_cnt + CNT_W'(cur_gap) + CNT_W'(1);
    end
  end

`ifndef NO_ASSERTIONS
  // each finished lookup counts exactly one access
  a_acc_step: assert property (@(posedge clk) disable iff (rst)
    finish |=> acc_cnt == $past(acc_cnt) + CNT_W'(1))
    else $error("access total did not step on a finished lookup");

  // a miss reports the way picked by the freshly advanced lfsr
  a_miss_way: assert property (@(posedge clk) disable iff (rst)
    finish && !hit && !seed_ld.load |=> rsp.way == OUT_WAY_W'(victim == victim ?
      ((WAYS > 1) ? lfsr[WAY_W-1:0] : '0) : '0))
    else $error("miss way differs from lfsr victim");

  // with a free result register a lookup leaves the lookup state in the next cycle
  a_lookup_len: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOOKUP && !rsp.valid |=> state == ST_IDLE)
    else $error("lookup stalled with a free result register");

  // no fill reaches the rams during the clear sweep
  a_no_fill_clr: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !tag_we && vld_wdata == '0)
    else $error("fill during valid clear sweep");
`endif

endmodule

[sv/set_assoc_cache_random_replace.sv]
// Set-associative cache tag store with random (lfsr) replacement.
// An item goes through the tag/valid ram read, compare-and-fill, then the result register.
// A new item is accepted only after the last one's lookup has finished.
// A stalled result register holds the lookup until the result is taken.
// Reset: synchronous; the valid ram's SETS (1024) rows are swept with no item accepted;
// the seed register may be written during the sweep. Seed resets to 1, totals to zero.
module set_assoc_cache_random_replace
  import sacrr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  sacrr_req_if.sink         req,
  sacrr_rsp_if.source       rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  seed_load_t            seed_ld;
  logic                  tag_we;
  logic [SET_W-1:0]      tag_waddr;
  logic [WAYS*TAG_W-1:0] tag_wdata;
  logic                  tag_re;
  logic [SET_W-1:0]      tag_raddr;
  logic [WAYS*TAG_W-1:0] tag_rdata;
  logic                  vld_we;
  logic [SET_W-1:0]      vld_waddr;
  logic [WAYS-1:0]       vld_wdata;
  logic                  vld_re;
  logic [SET_W-1:0]      vld_raddr;
  logic [WAYS-1:0]       vld_rdata;

  // seed register
  sacrr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .seed_ld (seed_ld)
  );

  // tag ram: one row of all ways per set
  sacrr_ram #(.WIDTH(WAYS * TAG_W), .DEPTH(SETS)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .re    (tag_re),
    .raddr (tag_raddr),
    .rdata (tag_rdata)
  );

  // valid ram: one bit per way, row per set
  sacrr_ram #(.WIDTH(WAYS), .DEPTH(SETS)) u_vld_ram (
    .clk   (clk),
    .we    (vld_we),
    .waddr (vld_waddr),
    .wdata (vld_wdata),
    .re    (vld_re),
    .raddr (vld_raddr),
    .rdata (vld_rdata)
  );

  // lookup control
  sacrr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .seed_ld   (seed_ld),
    .tag_we    (tag_we),
    .tag_waddr (tag_waddr),
    .tag_wdata (tag_wdata),
    .tag_re    (tag_re),
    .tag_raddr (tag_raddr),
    .tag_rdata (tag_rdata),
    .vld_we    (vld_we),
    .vld_waddr (vld_waddr),
    .vld_wdata (vld_wdata),
    .vld_re    (vld_re),
    .vld_raddr (vld_raddr),
    .vld_rdata (vld_rdata)
  );

endmodule
